>>> rtl/core/fps_pkg.sv
// Shared types, class codes and the protocol classifier for flow protocol statistics.
`default_nettype none

package fps_pkg;

  localparam int CntW   = 64;
  localparam int SecW   = 32;
  localparam int MsecW  = 10;
  localparam int ProtoW = 8;
  localparam int AggrW  = 32;
  localparam int NumClasses = 4;
  localparam int ClassW = $clog2(NumClasses);

  typedef logic [ClassW-1:0] class_t;

  localparam class_t CLASS_ICMP  = 2'd0;
  localparam class_t CLASS_TCP   = 2'd1;
  localparam class_t CLASS_UDP   = 2'd2;
  localparam class_t CLASS_OTHER = 2'd3;

  localparam logic [ProtoW-1:0] PROTO_ICMP   = 8'd1;
  localparam logic [ProtoW-1:0] PROTO_TCP    = 8'd6;
  localparam logic [ProtoW-1:0] PROTO_UDP    = 8'd17;
  localparam logic [ProtoW-1:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [SecW-1:0]  START_SEC_RESET  = '1;
  localparam logic [MsecW-1:0] START_MSEC_RESET = 10'd999;

  // One set of flow, packet and byte values (counters or increments)
  typedef struct packed {
    logic [CntW-1:0] flows;
    logic [CntW-1:0] packets;
    logic [CntW-1:0] bytes;
  } counters_t;

  // Timestamp as (seconds, milliseconds)
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [MsecW-1:0] msec;
  } stamp_t;

  // Item held in the update stage
  typedef struct packed {
    class_t    cls;
    counters_t delta;
    stamp_t    start;
    stamp_t    stop;
  } upd_item_t;

  function automatic class_t pick_class(input logic [ProtoW-1:0] proto);
    class_t c;
    unique case (proto) inside
      PROTO_ICMP, PROTO_ICMPV6: c = CLASS_ICMP;
      PROTO_TCP:                c = CLASS_TCP;
      PROTO_UDP:                c = CLASS_UDP;
      default:                  c = CLASS_OTHER;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fps_front.sv
// Input stage: classifies the record and registers its counter increments.
`default_nettype none

module fps_front (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [fps_pkg::ProtoW-1:0]    protocol,
  input  wire logic [fps_pkg::AggrW-1:0]     aggregate_flows,
  input  wire logic [fps_pkg::CntW-1:0]      in_packets,
  input  wire logic [fps_pkg::CntW-1:0]      out_packets,
  input  wire logic [fps_pkg::CntW-1:0]      in_bytes,
  input  wire logic [fps_pkg::CntW-1:0]      out_octets,
  input  wire logic [fps_pkg::SecW-1:0]      start_sec,
  input  wire logic [fps_pkg::MsecW-1:0]     start_msec,
  input  wire logic [fps_pkg::SecW-1:0]      end_sec,
  input  wire logic [fps_pkg::MsecW-1:0]     end_msec,
  output fps_pkg::class_t                    cls_now,
  output fps_pkg::upd_item_t                 item
);
  import fps_pkg::*;

  upd_item_t item_next;

  always_comb begin
    item_next.cls           = pick_class(protocol);
    // zero aggregate counts as a single flow
    item_next.delta.flows   = (aggregate_flows != '0) ? CntW'(aggregate_flows) : CntW'(1);
    item_next.delta.packets = in_packets + out_packets;
    item_next.delta.bytes   = in_bytes + out_octets;
    item_next.start.sec     = start_sec;
    item_next.start.msec    = start_msec;
    item_next.stop.sec      = end_sec;
    item_next.stop.msec     = end_msec;
  end

  assign cls_now = item_next.cls;

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fps_class_mem.sv
// Per-class counter memory with registered read and per-entry valid bits.
`default_nettype none

module fps_class_mem (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire fps_pkg::class_t      rd_addr,
  input  wire logic                 wr_en,
  input  wire fps_pkg::class_t      wr_addr,
  input  wire fps_pkg::counters_t   wr_data,
  output fps_pkg::counters_t        rd_data
);
  import fps_pkg::*;

  counters_t               mem [NumClasses];
  counters_t               rd_q;
  logic                    rd_ok;
  logic [NumClasses-1:0]   entry_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_ok       <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/flow_protocol_statistics_core.sv
// Top level: flow protocol statistics with class counters kept in a small memory.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | protocol, aggregate_flows, packets, bytes, times
//  out     | out_valid/out_ready| class_index, class and total counters, bounds
//
// One item per cycle sustained while out_ready is held high; an accepted item is
// registered in the update stage, then in the output register that drives out_valid.
// The class memory is read on accept and written back when the item leaves the update
// stage; a back to back item of the same class takes the value just written from the
// output register. Synchronous reset clears counters, time bounds and memory valid bits.
// The update stage holds while the output waits, and input is still taken while
// that stage is empty or moving on.
`default_nettype none

module flow_protocol_statistics_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fps_pkg::ProtoW-1:0]    protocol,
  input  wire logic [fps_pkg::AggrW-1:0]     aggregate_flows,
  input  wire logic [fps_pkg::CntW-1:0]      in_packets,
  input  wire logic [fps_pkg::CntW-1:0]      out_packets,
  input  wire logic [fps_pkg::CntW-1:0]      in_bytes,
  input  wire logic [fps_pkg::CntW-1:0]      out_octets,
  input  wire logic [fps_pkg::SecW-1:0]      start_sec,
  input  wire logic [fps_pkg::MsecW-1:0]     start_msec,
  input  wire logic [fps_pkg::SecW-1:0]      end_sec,
  input  wire logic [fps_pkg::MsecW-1:0]     end_msec,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fps_pkg::ClassW-1:0]         class_index,
  output logic [fps_pkg::CntW-1:0]           class_flows,
  output logic [fps_pkg::CntW-1:0]           class_packets,
  output logic [fps_pkg::CntW-1:0]           class_bytes,
  output logic [fps_pkg::CntW-1:0]           total_flows,
  output logic [fps_pkg::CntW-1:0]           total_packets,
  output logic [fps_pkg::CntW-1:0]           total_bytes,
  output logic [fps_pkg::SecW-1:0]           earliest_sec,
  output logic [fps_pkg::MsecW-1:0]          earliest_msec,
  output logic [fps_pkg::SecW-1:0]           latest_sec,
  output logic [fps_pkg::MsecW-1:0]          latest_msec
);
  import fps_pkg::*;

  logic       in_take;
  logic       upd_valid;
  logic       upd_move;
  logic       fwd_hit;
  class_t     cls_now;
  upd_item_t  item;
  counters_t  mem_rd;
  counters_t  base;
  counters_t  cls_next;
  counters_t  total;
  counters_t  total_next;
  stamp_t     min_start;
  stamp_t     max_end;
  stamp_t     min_start_next;
  stamp_t     max_end_next;

  assign upd_move = upd_valid && (!out_valid || out_ready);
  assign in_ready = !upd_valid || upd_move;
  assign in_take  = in_valid && in_ready;

  fps_front u_front (
    .clk             (clk),
    .load            (in_take),
    .protocol        (protocol),
    .aggregate_flows (aggregate_flows),
    .in_packets      (in_packets),
    .out_packets     (out_packets),
    .in_bytes        (in_bytes),
    .out_octets      (out_octets),
    .start_sec       (start_sec),
    .start_msec      (start_msec),
    .end_sec         (end_sec),
    .end_msec        (end_msec),
    .cls_now         (cls_now),
    .item            (item)
  );

  fps_class_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_take),
    .rd_addr (cls_now),
    .wr_en   (upd_move),
    .wr_addr (item.cls),
    .wr_data (cls_next),
    .rd_data (mem_rd)
  );

  // read and write of the same class at one edge: memory returns the old value
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (in_take) begin
        upd_valid <= 1'b1;
        fwd_hit   <= upd_move && (item.cls == cls_now);
      end else if (upd_move) begin
        upd_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    base.flows   = class_flows;
    base.packets = class_packets;
    base.bytes   = class_bytes;
    if (!fwd_hit) begin
      base = mem_rd;
    end
    cls_next.flows     = base.flows + item.delta.flows;
    cls_next.packets   = base.packets + item.delta.packets;
    cls_next.bytes     = base.bytes + item.delta.bytes;
    total_next.flows   = total.flows + item.delta.flows;
    total_next.packets = total.packets + item.delta.packets;
    total_next.bytes   = total.bytes + item.delta.bytes;

    min_start_next = min_start;
    if ((item.start.sec < min_start.sec) ||
        ((item.start.sec == min_start.sec) && (item.start.msec < min_start.msec))) begin
      min_start_next = item.start;
    end
    max_end_next = max_end;
    if ((item.stop.sec > max_end.sec) ||
        ((item.stop.sec == max_end.sec) && (item.stop.msec > max_end.msec))) begin
      max_end_next = item.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total          <= '0;
      min_start.sec  <= START_SEC_RESET;
      min_start.msec <= START_MSEC_RESET;
      max_end        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (upd_move) begin
        total     <= total_next;
        min_start <= min_start_next;
        max_end   <= max_end_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_move) begin
      class_index   <= item.cls;
      class_flows   <= cls_next.flows;
      class_packets <= cls_next.packets;
      class_bytes   <= cls_next.bytes;
      total_flows   <= total_next.flows;
      total_packets <= total_next.packets;
      total_bytes   <= total_next.bytes;
      earliest_sec  <= min_start_next.sec;
      earliest_msec <= min_start_next.msec;
      latest_sec    <= max_end_next.sec;
      latest_msec   <= max_end_next.msec;
    end
  end

endmodule

`default_nettype wire

>>> test/tb_flow_protocol_statistics_core.sv
// Testbench for flow_protocol_statistics_core: directed table, random flows, scoreboard.
`timescale 1ns / 100ps

module tb_flow_protocol_statistics_core;
  import fps_pkg::*;

  localparam int CycleLimit = 100000;

  typedef struct packed {
    logic [ProtoW-1:0] proto;
    logic [AggrW-1:0]  aggr;
    logic [CntW-1:0]   pkts_in;
    logic [CntW-1:0]   pkts_out;
    logic [CntW-1:0]   bytes_in;
    logic [CntW-1:0]   bytes_out;
    stamp_t            start;
    stamp_t            stop;
  } flow_rec_t;

  typedef struct packed {
    class_t          cls;
    logic [CntW-1:0] cls_flows;
    logic [CntW-1:0] cls_pkts;
    logic [CntW-1:0] cls_bytes;
    logic [CntW-1:0] tot_flows;
    logic [CntW-1:0] tot_pkts;
    logic [CntW-1:0] tot_bytes;
    stamp_t          earliest;
    stamp_t          latest;
  } flow_stats_t;

  typedef struct {
    bit          typed;
    flow_stats_t stats;
  } row_check_t;

  typedef struct {
    flow_rec_t   rec;
    bit          typed;
    flow_stats_t stats;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [ProtoW-1:0]   protocol;
  logic [AggrW-1:0]    aggregate_flows;
  logic [CntW-1:0]     in_packets;
  logic [CntW-1:0]     out_packets;
  logic [CntW-1:0]     in_bytes;
  logic [CntW-1:0]     out_octets;
  logic [SecW-1:0]     start_sec;
  logic [MsecW-1:0]    start_msec;
  logic [SecW-1:0]     end_sec;
  logic [MsecW-1:0]    end_msec;
  logic                out_valid;
  logic                out_ready;
  logic [ClassW-1:0]   class_index;
  logic [CntW-1:0]     class_flows;
  logic [CntW-1:0]     class_packets;
  logic [CntW-1:0]     class_bytes;
  logic [CntW-1:0]     total_flows;
  logic [CntW-1:0]     total_packets;
  logic [CntW-1:0]     total_bytes;
  logic [SecW-1:0]     earliest_sec;
  logic [MsecW-1:0]    earliest_msec;
  logic [SecW-1:0]     latest_sec;
  logic [MsecW-1:0]    latest_msec;

  // predictor state
  logic [CntW-1:0] class_flows_acc [NumClasses];
  logic [CntW-1:0] class_pkts_acc  [NumClasses];
  logic [CntW-1:0] class_bytes_acc [NumClasses];
  logic [CntW-1:0] all_flows_acc;
  logic [CntW-1:0] all_pkts_acc;
  logic [CntW-1:0] all_bytes_acc;
  stamp_t          min_start;
  stamp_t          max_stop;

  flow_stats_t pending_stats[$];
  row_check_t  row_checks[$];
  stim_row_t   directed_rows[$];

  int          idle_pct;
  int          stall_pct;
  int          hold_len;
  int          err_count;
  int          results_seen;
  int          cycle_count;
  logic [SecW-1:0] lo_cur;
  logic [SecW-1:0] hi_cur;
  flow_rec_t   prev_rec;

  flow_protocol_statistics_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .protocol        (protocol),
    .aggregate_flows (aggregate_flows),
    .in_packets      (in_packets),
    .out_packets     (out_packets),
    .in_bytes        (in_bytes),
    .out_octets      (out_octets),
    .start_sec       (start_sec),
    .start_msec      (start_msec),
    .end_sec         (end_sec),
    .end_msec        (end_msec),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .class_index     (class_index),
    .class_flows     (class_flows),
    .class_packets   (class_packets),
    .class_bytes     (class_bytes),
    .total_flows     (total_flows),
    .total_packets   (total_packets),
    .total_bytes     (total_bytes),
    .earliest_sec    (earliest_sec),
    .earliest_msec   (earliest_msec),
    .latest_sec      (latest_sec),
    .latest_msec     (latest_msec)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic flow_rec_t mk_flow(logic [ProtoW-1:0] proto, logic [AggrW-1:0] aggr,
                                        logic [CntW-1:0] pi, logic [CntW-1:0] po,
                                        logic [CntW-1:0] bi, logic [CntW-1:0] bo,
                                        logic [SecW-1:0] ss, logic [MsecW-1:0] sm,
                                        logic [SecW-1:0] es, logic [MsecW-1:0] em);
    flow_rec_t r;
    r.proto      = proto;
    r.aggr       = aggr;
    r.pkts_in    = pi;
    r.pkts_out   = po;
    r.bytes_in   = bi;
    r.bytes_out  = bo;
    r.start.sec  = ss;
    r.start.msec = sm;
    r.stop.sec   = es;
    r.stop.msec  = em;
    return r;
  endfunction

  // Adds one flow to the running counters and returns the updated view.
  function automatic flow_stats_t accumulate_flow(flow_rec_t r);
    class_t          c;
    logic [CntW-1:0] nflows;
    logic [CntW-1:0] npkts;
    logic [CntW-1:0] nbytes;
    flow_stats_t     s;
    case (r.proto) inside
      PROTO_ICMP, PROTO_ICMPV6: c = CLASS_ICMP;
      PROTO_TCP:                c = CLASS_TCP;
      PROTO_UDP:                c = CLASS_UDP;
      default:                  c = CLASS_OTHER;
    endcase
    nflows = (r.aggr == '0) ? 64'd1 : {32'd0, r.aggr};
    npkts  = r.pkts_in + r.pkts_out;
    nbytes = r.bytes_in + r.bytes_out;
    class_flows_acc[c] += nflows;
    class_pkts_acc[c]  += npkts;
    class_bytes_acc[c] += nbytes;
    all_flows_acc += nflows;
    all_pkts_acc  += npkts;
    all_bytes_acc += nbytes;
    // packed {sec, msec} compares lexicographically; ties leave state alone
    if (r.start < min_start) min_start = r.start;
    if (r.stop > max_stop) max_stop = r.stop;
    s.cls       = c;
    s.cls_flows = class_flows_acc[c];
    s.cls_pkts  = class_pkts_acc[c];
    s.cls_bytes = class_bytes_acc[c];
    s.tot_flows = all_flows_acc;
    s.tot_pkts  = all_pkts_acc;
    s.tot_bytes = all_bytes_acc;
    s.earliest  = min_start;
    s.latest    = max_stop;
    return s;
  endfunction

  function automatic logic [CntW-1:0] rand_count();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return 64'($urandom_range(1000));
    else if (pick < 9) return {$urandom, $urandom};
    else return ~64'($urandom_range(50));
  endfunction

  function automatic logic [MsecW-1:0] rand_msec();
    if ($urandom_range(9) == 0) return 10'($urandom_range(1000, 1023));
    return 10'($urandom_range(999));
  endfunction

  // Bounds drift outward so min/max keep moving; some items repeat the last stamps.
  function automatic flow_rec_t random_flow();
    flow_rec_t r;
    int        pick;
    pick = $urandom_range(9);
    case (pick) inside
      0, 1:    r.proto = PROTO_TCP;
      2:       r.proto = PROTO_UDP;
      3:       r.proto = PROTO_ICMP;
      4:       r.proto = PROTO_ICMPV6;
      default: r.proto = 8'($urandom_range(255));
    endcase
    pick = $urandom_range(19);
    if (pick < 4) r.aggr = '0;
    else if (pick < 14) r.aggr = 32'($urandom_range(1, 100));
    else if (pick < 19) r.aggr = $urandom;
    else r.aggr = '1;
    r.pkts_in   = rand_count();
    r.pkts_out  = rand_count();
    r.bytes_in  = rand_count();
    r.bytes_out = rand_count();
    lo_cur -= 32'($urandom_range(2));
    hi_cur += 32'($urandom_range(2));
    pick = $urandom_range(19);
    if (pick == 0) begin
      r.start = prev_rec.start;
      r.stop  = prev_rec.stop;
    end else begin
      r.start.sec  = (pick == 1) ? ($urandom | 32'hA000_0000)
                                 : lo_cur + 32'($urandom_range(40)) - 32'd20;
      r.stop.sec   = (pick == 2) ? ($urandom & 32'h5FFF_FFFF)
                                 : hi_cur + 32'($urandom_range(40)) - 32'd20;
      r.start.msec = rand_msec();
      r.stop.msec  = rand_msec();
    end
    prev_rec = r;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    // keep the log short if everything goes wrong
    if (err_count < 50) $display("result %0d: %s", results_seen, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic compare_result(flow_stats_t want);
    check_field("class_index", 64'(class_index), 64'(want.cls));
    check_field("class_flows", class_flows, want.cls_flows);
    check_field("class_packets", class_packets, want.cls_pkts);
    check_field("class_bytes", class_bytes, want.cls_bytes);
    check_field("total_flows", total_flows, want.tot_flows);
    check_field("total_packets", total_packets, want.tot_pkts);
    check_field("total_bytes", total_bytes, want.tot_bytes);
    check_field("earliest_sec", 64'(earliest_sec), 64'(want.earliest.sec));
    check_field("earliest_msec", 64'(earliest_msec), 64'(want.earliest.msec));
    check_field("latest_sec", 64'(latest_sec), 64'(want.latest.sec));
    check_field("latest_msec", 64'(latest_msec), 64'(want.latest.msec));
  endtask

  task automatic send_flow(flow_rec_t r, bit typed, flow_stats_t s);
    row_check_t rc;
    rc.typed = typed;
    rc.stats = s;
    row_checks.push_back(rc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    protocol        <= r.proto;
    aggregate_flows <= r.aggr;
    in_packets      <= r.pkts_in;
    out_packets     <= r.pkts_out;
    in_bytes        <= r.bytes_in;
    out_octets      <= r.bytes_out;
    start_sec       <= r.start.sec;
    start_msec      <= r.start.msec;
    end_sec         <= r.stop.sec;
    end_msec        <= r.stop.msec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // scoreboard: results first, since an item accepted now cannot emerge at this edge
  always @(posedge clk) begin : scoreboard
    flow_rec_t   r;
    flow_stats_t want;
    row_check_t  rc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = pending_stats.pop_front();
          compare_result(want);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        r.proto      = protocol;
        r.aggr       = aggregate_flows;
        r.pkts_in    = in_packets;
        r.pkts_out   = out_packets;
        r.bytes_in   = in_bytes;
        r.bytes_out  = out_octets;
        r.start.sec  = start_sec;
        r.start.msec = start_msec;
        r.stop.sec   = end_sec;
        r.stop.msec  = end_msec;
        want = accumulate_flow(r);
        if (row_checks.size() != 0) begin
          rc = row_checks.pop_front();
          if (rc.typed) want = rc.stats;
        end
        pending_stats.push_back(want);
      end
    end
  end

  // receiver; a requested hold-off is counted here
  initial begin : receiver
    int hold_cnt;
    hold_cnt = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt != 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[flow_protocol_statistics_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    protocol        <= '0;
    aggregate_flows <= '0;
    in_packets      <= '0;
    out_packets     <= '0;
    in_bytes        <= '0;
    out_octets      <= '0;
    start_sec       <= '0;
    start_msec      <= '0;
    end_sec         <= '0;
    end_msec        <= '0;
    idle_pct     = 15;
    stall_pct    = 15;
    hold_len     = 0;
    err_count    = 0;
    results_seen = 0;
    cycle_count  = 0;
    lo_cur       = 32'h8FFF_FF00;
    hi_cur       = 32'h7000_0100;
    prev_rec     = '0;
    for (int i = 0; i < NumClasses; i++) begin
      class_flows_acc[i] = '0;
      class_pkts_acc[i]  = '0;
      class_bytes_acc[i] = '0;
    end
    all_flows_acc = '0;
    all_pkts_acc  = '0;
    all_bytes_acc = '0;
    min_start     = {START_SEC_RESET, START_MSEC_RESET};
    max_stop      = '0;

    // 1000 ms at all-ones seconds is not below the reset minimum; end ties at zero
    directed_rows.push_back('{mk_flow(PROTO_TCP, 32'd0, 64'd1, 64'd2, 64'd10, 64'd20,
                                      32'hFFFF_FFFF, 10'd1000, 32'd0, 10'd0), 1'b1,
                              '{CLASS_TCP, 64'd1, 64'd3, 64'd30, 64'd1, 64'd3, 64'd30,
                                stamp_t'{32'hFFFF_FFFF, 10'd999}, stamp_t'{32'd0, 10'd0}}});
    // counter extremes, sums wrap
    directed_rows.push_back('{mk_flow(PROTO_ICMP, '1, '1, '1, '1, 64'd1,
                                      32'hFFFF_FFFF, 10'd998, 32'd0, 10'd1), 1'b1,
                              '{CLASS_ICMP, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0,
                                64'h1_0000_0000, 64'd1, 64'd30,
                                stamp_t'{32'hFFFF_FFFF, 10'd998}, stamp_t'{32'd0, 10'd1}}});
    directed_rows.push_back('{mk_flow(PROTO_ICMPV6, 32'd1, 64'd0, 64'd0, 64'd0, 64'd0,
                                      32'hFFFF_FFFF, 10'd998, 32'd0, 10'd1), 1'b0, '0});
    directed_rows.push_back('{mk_flow(PROTO_UDP, 32'd5, 64'd7, 64'd0, 64'd0, 64'd9,
                                      32'h9000_0000, 10'd999, 32'h7000_0000, 10'd0), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd0, 32'd0, 64'd1, 64'd1, 64'd64, 64'd64,
                                      32'h9000_0000, 10'd1023, 32'h7000_0000, 10'd1023),
                              1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd255, 32'd2, 64'd3, 64'd4, 64'd5, 64'd6,
                                      32'h8FFF_FFFF, 10'd1023, 32'h7000_0001, 10'd0), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd2, 32'd0, 64'd1, 64'd0, 64'd40, 64'd0,
                                      32'h8FFF_FFFF, 10'd500, 32'h7000_0001, 10'd0), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd5, 32'd1, 64'd2, 64'd2, 64'd2, 64'd2,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd7, 32'd3, 64'd1, 64'd1, 64'd1, 64'd1,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd16, 32'd4, 64'd9, 64'd0, 64'd90, 64'd0,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd18, 32'd0, 64'd0, 64'd9, 64'd0, 64'd90,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd57, 32'd8, 64'd5, 64'd5, 64'd50, 64'd50,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(8'd59, 32'd9, 64'd6, 64'd6, 64'd60, 64'd60,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(PROTO_TCP, '1, '1, 64'd0, '1, 64'd0,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});
    directed_rows.push_back('{mk_flow(PROTO_UDP, 32'd1, 64'd0, '1, 64'd0, '1,
                                      32'h8FFF_FFFF, 10'd600, 32'h6FFF_FFFF, 10'd999), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_flow(directed_rows[i].rec, directed_rows[i].typed,
                                         directed_rows[i].stats);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_len  = 400;  // long hold-off, input must back up
        end
        1: begin
          idle_pct  = 75;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 75;
        end
        default: begin
          idle_pct  = 15;
          stall_pct = 15;
        end
      endcase
      repeat (133) send_flow(random_flow(), 1'b0, '0);
    end

    // time extremes last, so the bounds keep moving during the random part
    send_flow(mk_flow(PROTO_UDP, 32'd3, 64'd1, 64'd1, 64'd1, 64'd1,
                      32'd0, 10'd0, 32'hFFFF_FFFF, 10'd1023), 1'b0, '0);
    send_flow(mk_flow(8'd200, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                      32'd0, 10'd0, 32'hFFFF_FFFF, 10'd1023), 1'b0, '0);

    in_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[flow_protocol_statistics_core] OK");
    end else begin
      $display("[flow_protocol_statistics_core] ERROR");
    end
    $finish;
  end

endmodule
